// ===== rtl/krt_pkg.sv =====
// Shared types, codes and constants for the keyed record table.
// No dependencies; used by every module of the block.
package krt_pkg;

	localparam int DEPTH_DEF = 512;

	localparam int KEY_W = 20;
	localparam int PAY_W = 16;
	localparam int OP_W  = 2;
	localparam int ST_W  = 2;
	localparam int IDX_W = 9;
	localparam int CNT_W = 10;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 40;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
	localparam logic [OP_W-1:0] OP_SORT   = 2'd3;

	localparam logic [ST_W-1:0] ST_DONE     = 2'd0;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL     = 2'd2;

	typedef struct packed {
		logic [PAY_W-1:0] pay;
		logic [KEY_W-1:0] key;
	} rec_t;

	typedef struct packed {
		logic eq;
		logic lt;
	} cmp_res_t;

endpackage

// ===== rtl/krt_store.sv =====
// Record memory: one write port, one read port with registered read data.
// Depends on krt_pkg for the record type.
module krt_store #(
	parameter int DEPTH = krt_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  krt_pkg::rec_t      wdata,
	input  logic [AW-1:0]      raddr,
	output krt_pkg::rec_t      rdata
);

	krt_pkg::rec_t mem_q [DEPTH];
	krt_pkg::rec_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/krt_cmp.sv =====
// Shared key comparator used by lookup, delete and sort.
// Depends on krt_pkg for key width and result type.
module krt_cmp (
	input  logic [krt_pkg::KEY_W-1:0] a,
	input  logic [krt_pkg::KEY_W-1:0] b,
	output krt_pkg::cmp_res_t         res
);

	always_comb begin
		res.eq = (a == b);
		res.lt = (a < b);
	end

endmodule

// ===== rtl/keyed_record_table.sv =====
// Keyed record table top level: sequencer, result register and wiring.
// Depends on krt_pkg, krt_store and krt_cmp.
//
//  channel   dir  beat contents
//  s_*       in   tuser: op; tdata: key, payload
//  m_*       out  tuser: status; tdata: index, found_payload, entry_count
//
// Insert writes from idle, then finishes; lookup and delete read, then evaluate, each entry scanned.
// Sort of n entries reads, then compares, each pair of entries in turn through the
// single memory read port. One beat at a time: s_tready is high only when idle.
// Reset clears the count and control; the memory needs no clearing pass.
// A finished result waits in the output register; a stalled m_tready holds it.
module keyed_record_table #(
	parameter int DEPTH = krt_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [krt_pkg::OP_W-1:0]          s_tuser,  // [1:0] op
	input  logic [krt_pkg::IN_DATA_W-1:0]     s_tdata,  // [19:0] key, [35:20] payload, zero pad
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [krt_pkg::ST_W-1:0]          m_tuser,  // [1:0] status
	output logic [krt_pkg::OUT_DATA_W-1:0]    m_tdata   // [8:0] index, [24:9] found_payload,
	                                                    // [34:25] entry_count, zero pad
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PAD_W = krt_pkg::OUT_DATA_W - krt_pkg::IDX_W - krt_pkg::PAY_W
		- krt_pkg::CNT_W;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_SCAN_RD = 4'd1;
	localparam logic [3:0] S_SCAN_EV = 4'd2;
	localparam logic [3:0] S_SORT_RI = 4'd3;
	localparam logic [3:0] S_SORT_LI = 4'd4;
	localparam logic [3:0] S_SORT_RJ = 4'd5;
	localparam logic [3:0] S_SORT_CJ = 4'd6;
	localparam logic [3:0] S_SORT_WI = 4'd7;
	localparam logic [3:0] S_FIN     = 4'd8;

	logic [3:0]                  state_q;
	logic [CW-1:0]               cnt_q;
	logic [CW-1:0]               kept_q;
	logic [AW-1:0]               i_q;
	logic [AW-1:0]               j_q;
	logic [krt_pkg::OP_W-1:0]    op_q;
	logic [krt_pkg::KEY_W-1:0]   key_q;
	krt_pkg::rec_t               cur_q;

	logic [krt_pkg::ST_W-1:0]    res_st_q;
	logic [AW-1:0]               res_idx_q;
	logic [krt_pkg::PAY_W-1:0]   res_pay_q;

	logic                        out_valid_q;
	logic [krt_pkg::ST_W-1:0]    out_st_q;
	logic [krt_pkg::IDX_W-1:0]   out_idx_q;
	logic [krt_pkg::PAY_W-1:0]   out_pay_q;
	logic [krt_pkg::CNT_W-1:0]   out_cnt_q;

	logic                        mem_we;
	logic [AW-1:0]               mem_waddr;
	krt_pkg::rec_t               mem_wdata;
	logic [AW-1:0]               mem_raddr;
	krt_pkg::rec_t               mem_rdata;

	logic [krt_pkg::KEY_W-1:0]   cmp_b;
	krt_pkg::cmp_res_t           cmp;

	logic                        accept;
	logic                        out_free;
	logic                        scan_last;
	logic                        j_last;
	logic                        i_last;
	logic [CW-1:0]               kept_nxt;
	krt_pkg::rec_t               in_rec;

	krt_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	krt_cmp u_cmp (
		.a   (mem_rdata.key),
		.b   (cmp_b),
		.res (cmp)
	);

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	assign in_rec.key = s_tdata[krt_pkg::KEY_W-1:0];
	assign in_rec.pay = s_tdata[krt_pkg::KEY_W +: krt_pkg::PAY_W];

	assign cmp_b     = (state_q == S_SORT_CJ) ? cur_q.key : key_q;
	assign scan_last = (CW'(i_q) == cnt_q - CW'(1));
	assign j_last    = (CW'(j_q) == cnt_q - CW'(1));
	assign i_last    = (CW'(i_q) + CW'(2) == cnt_q);
	assign kept_nxt  = kept_q + CW'(!cmp.eq);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = i_q;
		mem_wdata = cur_q;
		mem_raddr = i_q;
		case (state_q)
			S_IDLE: begin
				mem_waddr = cnt_q[AW-1:0];
				mem_wdata = in_rec;
				mem_we    = accept && (s_tuser == krt_pkg::OP_INSERT)
					&& (cnt_q != CW'(DEPTH));
			end
			S_SCAN_EV: begin
				mem_waddr = kept_q[AW-1:0];
				mem_wdata = mem_rdata;
				mem_we    = (op_q == krt_pkg::OP_DELETE) && !cmp.eq;
			end
			S_SORT_RJ: begin
				mem_raddr = j_q;
			end
			S_SORT_CJ: begin
				mem_waddr = j_q;
				mem_wdata = cur_q;
				mem_we    = cmp.lt;
			end
			S_SORT_WI: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (s_tuser)
							krt_pkg::OP_INSERT: begin
								state_q <= S_FIN;
								if (cnt_q != CW'(DEPTH)) begin
									cnt_q <= cnt_q + CW'(1);
								end
							end
							krt_pkg::OP_DELETE, krt_pkg::OP_LOOKUP: begin
								state_q <= (cnt_q == '0) ? S_FIN : S_SCAN_RD;
							end
							default: begin
								state_q <= (cnt_q < CW'(2)) ? S_FIN : S_SORT_RI;
							end
						endcase
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_EV;
				end
				S_SCAN_EV: begin
					if (op_q == krt_pkg::OP_LOOKUP && cmp.eq) begin
						state_q <= S_FIN;
					end else if (scan_last) begin
						state_q <= S_FIN;
						if (op_q == krt_pkg::OP_DELETE && kept_nxt != cnt_q) begin
							cnt_q <= kept_nxt;
						end
					end else begin
						state_q <= S_SCAN_RD;
					end
				end
				S_SORT_RI: begin
					state_q <= S_SORT_LI;
				end
				S_SORT_LI: begin
					state_q <= S_SORT_RJ;
				end
				S_SORT_RJ: begin
					state_q <= S_SORT_CJ;
				end
				S_SORT_CJ: begin
					state_q <= j_last ? S_SORT_WI : S_SORT_RJ;
				end
				S_SORT_WI: begin
					state_q <= i_last ? S_FIN : S_SORT_RI;
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q      <= s_tuser;
				key_q     <= in_rec.key;
				i_q       <= '0;
				kept_q    <= '0;
				res_st_q  <= krt_pkg::ST_DONE;
				res_idx_q <= '0;
				res_pay_q <= '0;
				if (s_tuser == krt_pkg::OP_INSERT) begin
					if (cnt_q == CW'(DEPTH)) begin
						res_st_q <= krt_pkg::ST_FULL;
					end else begin
						res_idx_q <= cnt_q[AW-1:0];
					end
				end else if (s_tuser != krt_pkg::OP_SORT && cnt_q == '0) begin
					res_st_q <= krt_pkg::ST_NOTFOUND;
				end
			end
			S_SCAN_EV: begin
				kept_q <= kept_nxt;
				i_q    <= i_q + AW'(1);
				if (op_q == krt_pkg::OP_LOOKUP) begin
					if (cmp.eq) begin
						res_idx_q <= i_q;
						res_pay_q <= mem_rdata.pay;
					end else if (scan_last) begin
						res_st_q <= krt_pkg::ST_NOTFOUND;
					end
				end else if (scan_last && kept_nxt == cnt_q) begin
					res_st_q <= krt_pkg::ST_NOTFOUND;
				end
			end
			S_SORT_LI: begin
				cur_q <= mem_rdata;
				j_q   <= i_q + AW'(1);
			end
			S_SORT_CJ: begin
				if (cmp.lt) begin
					cur_q <= mem_rdata;
				end
				j_q <= j_q + AW'(1);
			end
			S_SORT_WI: begin
				i_q <= i_q + AW'(1);
			end
			default: begin
				i_q <= i_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			out_st_q  <= res_st_q;
			out_idx_q <= krt_pkg::IDX_W'(res_idx_q);
			out_pay_q <= res_pay_q;
			out_cnt_q <= krt_pkg::CNT_W'(cnt_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_st_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_cnt_q, out_pay_q, out_idx_q};

endmodule

// ===== verif/tb.sv =====
// Self-checking bench for keyed_record_table: directed table, then random insert, delete,
// lookup and sort traffic checked beat by beat against a behavioural copy of the table.
// Depends on krt_pkg and rtl/keyed_record_table.sv.
module tb;

	localparam int TBL_DEPTH    = krt_pkg::DEPTH_DEF;
	localparam int POOL_N       = 24;
	localparam int SMALL_CAP    = 48;
	localparam int HOLD_CYCLES  = 600;
	localparam int DRAIN_CYCLES = 20;
	localparam int STALL_LIMIT  = 1200000;
	localparam int IN_PAD_W     = krt_pkg::IN_DATA_W - krt_pkg::KEY_W - krt_pkg::PAY_W;

	typedef struct packed {
		logic [krt_pkg::ST_W-1:0]  status;
		logic [krt_pkg::IDX_W-1:0] index;
		logic [krt_pkg::PAY_W-1:0] pay;
		logic [krt_pkg::CNT_W-1:0] count;
	} resp_t;

	typedef struct {
		logic [krt_pkg::OP_W-1:0]  op;
		logic [krt_pkg::KEY_W-1:0] key;
		logic [krt_pkg::PAY_W-1:0] pay;
		bit                        chk;
		resp_t                     resp;
	} stim_row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [krt_pkg::OP_W-1:0]       s_tuser;    // [1:0] op
	logic [krt_pkg::IN_DATA_W-1:0]  s_tdata;    // [19:0] key, [35:20] payload, zero pad
	logic                           m_tvalid;
	logic                           m_tready;
	logic [krt_pkg::ST_W-1:0]       m_tuser;    // [1:0] status
	logic [krt_pkg::OUT_DATA_W-1:0] m_tdata;    // [8:0] index, [24:9] found_payload,
	                                            // [34:25] entry_count, zero pad

	logic [krt_pkg::KEY_W-1:0] tbl_key [TBL_DEPTH];
	logic [krt_pkg::PAY_W-1:0] tbl_pay [TBL_DEPTH];
	int                        tbl_count;
	logic [krt_pkg::KEY_W-1:0] key_pool [POOL_N];
	resp_t                     pending_resp [$];
	stim_row_t                 directed [$];
	int                        mismatch_count;
	int                        sent_count;
	int                        recv_count;
	int                        stall_cycles;

	keyed_record_table #(.DEPTH(TBL_DEPTH)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic resp_t table_apply(input logic [krt_pkg::OP_W-1:0] op,
			input logic [krt_pkg::KEY_W-1:0] key, input logic [krt_pkg::PAY_W-1:0] pay);
		resp_t                     r;
		int                        i;
		int                        j;
		int                        kept;
		int                        hit;
		logic [krt_pkg::KEY_W-1:0] tk;
		logic [krt_pkg::PAY_W-1:0] tp;
		r = '0;
		r.status = krt_pkg::ST_DONE;
		case (op)
			krt_pkg::OP_INSERT: begin
				if (tbl_count >= TBL_DEPTH) begin
					r.status = krt_pkg::ST_FULL;
				end else begin
					tbl_key[tbl_count] = key;
					tbl_pay[tbl_count] = pay;
					r.index = krt_pkg::IDX_W'(tbl_count);
					tbl_count++;
				end
			end
			krt_pkg::OP_DELETE: begin
				kept = 0;
				for (i = 0; i < tbl_count; i++) begin
					if (tbl_key[i] != key) begin
						tbl_key[kept] = tbl_key[i];
						tbl_pay[kept] = tbl_pay[i];
						kept++;
					end
				end
				if (kept == tbl_count)
					r.status = krt_pkg::ST_NOTFOUND;
				else
					tbl_count = kept;
			end
			krt_pkg::OP_LOOKUP: begin
				hit = -1;
				for (i = 0; i < tbl_count && hit < 0; i++)
					if (tbl_key[i] == key)
						hit = i;
				if (hit < 0) begin
					r.status = krt_pkg::ST_NOTFOUND;
				end else begin
					r.index = krt_pkg::IDX_W'(hit);
					r.pay = tbl_pay[hit];
				end
			end
			default: begin
				for (i = 0; i + 1 < tbl_count; i++) begin
					for (j = i + 1; j < tbl_count; j++) begin
						if (tbl_key[j] < tbl_key[i]) begin
							tk = tbl_key[i];
							tp = tbl_pay[i];
							tbl_key[i] = tbl_key[j];
							tbl_pay[i] = tbl_pay[j];
							tbl_key[j] = tk;
							tbl_pay[j] = tp;
						end
					end
				end
			end
		endcase
		r.count = krt_pkg::CNT_W'(tbl_count);
		return r;
	endfunction

	function automatic int draw_gap(input int n, input int quiet_phase);
		if ((n / 100) % 4 == quiet_phase)
			return 0;
		return $urandom_range(0, 9);
	endfunction

	function automatic logic [krt_pkg::KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		if (r < 6)
			return key_pool[$urandom_range(0, POOL_N - 1)];
		return krt_pkg::KEY_W'($urandom);
	endfunction

	task automatic refresh_pool();
		int k;
		for (k = 0; k < POOL_N; k++)
			key_pool[k] = krt_pkg::KEY_W'($urandom);
		key_pool[0] = '0;
		key_pool[1] = '1;
	endtask

	task automatic add_row(input logic [krt_pkg::OP_W-1:0] op,
			input logic [krt_pkg::KEY_W-1:0] key, input logic [krt_pkg::PAY_W-1:0] pay,
			input bit chk, input logic [krt_pkg::ST_W-1:0] st,
			input int idx, input int fp, input int cnt);
		stim_row_t row;
		row.op = op;
		row.key = key;
		row.pay = pay;
		row.chk = chk;
		row.resp.status = st;
		row.resp.index = krt_pkg::IDX_W'(idx);
		row.resp.pay = krt_pkg::PAY_W'(fp);
		row.resp.count = krt_pkg::CNT_W'(cnt);
		directed.push_back(row);
	endtask

	task automatic issue_op(input logic [krt_pkg::OP_W-1:0] op,
			input logic [krt_pkg::KEY_W-1:0] key, input logic [krt_pkg::PAY_W-1:0] pay,
			input bit chk, input resp_t typed);
		int    gap;
		resp_t pred;
		gap = draw_gap(sent_count, 2);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {{IN_PAD_W{1'b0}}, pay, key};
		do @(posedge clk); while (!s_tready);
		pred = table_apply(op, key, pay);
		pending_resp.push_back(chk ? typed : pred);
		sent_count++;
	endtask

	task automatic run_small(input int n);
		int                       k;
		int                       r;
		logic [krt_pkg::OP_W-1:0] op;
		for (k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (tbl_count >= SMALL_CAP && r < 40)
				r = 70;
			if (r < 40)
				op = krt_pkg::OP_INSERT;
			else if (r < 65)
				op = krt_pkg::OP_LOOKUP;
			else if (r < 92)
				op = krt_pkg::OP_DELETE;
			else
				op = krt_pkg::OP_SORT;
			issue_op(op, pick_key(), krt_pkg::PAY_W'($urandom), 1'b0, '0);
		end
	endtask

	// receiver: random hold-offs, two long stalls to back the block up
	initial begin
		int gap;
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			gap = draw_gap(recv_count, 1);
			if (recv_count == 300 || recv_count == 900)
				gap = HOLD_CYCLES;
			@(negedge clk);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		resp_t got;
		resp_t exp_r;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (arst_n && m_tvalid && m_tready) begin
			recv_count++;
			got.status = m_tuser;
			got.index = m_tdata[krt_pkg::IDX_W-1:0];
			got.pay = m_tdata[krt_pkg::IDX_W +: krt_pkg::PAY_W];
			got.count = m_tdata[krt_pkg::IDX_W + krt_pkg::PAY_W +: krt_pkg::CNT_W];
			if (pending_resp.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected beat: st=%0d idx=%0d pay=%h cnt=%0d",
						got.status, got.index, got.pay, got.count);
			end else begin
				exp_r = pending_resp.pop_front();
				if (got.status !== exp_r.status || got.index !== exp_r.index ||
						got.pay !== exp_r.pay || got.count !== exp_r.count) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("beat %0d exp %0d/%0d/%h/%0d got %0d/%0d/%h/%0d",
							recv_count, exp_r.status, exp_r.index, exp_r.pay,
							exp_r.count, got.status, got.index, got.pay, got.count);
				end
			end
		end
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int i;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = '0;
		s_tdata = '0;
		tbl_count = 0;
		mismatch_count = 0;
		sent_count = 0;
		recv_count = 0;
		stall_cycles = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		add_row(krt_pkg::OP_LOOKUP, 20'h00000, 16'h0000, 1'b1, krt_pkg::ST_NOTFOUND, 0, 0, 0);
		add_row(krt_pkg::OP_DELETE, 20'hFFFFF, 16'hFFFF, 1'b1, krt_pkg::ST_NOTFOUND, 0, 0, 0);
		add_row(krt_pkg::OP_SORT,   20'h00000, 16'h0000, 1'b1, krt_pkg::ST_DONE, 0, 0, 0);
		add_row(krt_pkg::OP_INSERT, 20'h00000, 16'h0000, 1'b1, krt_pkg::ST_DONE, 0, 0, 1);
		add_row(krt_pkg::OP_INSERT, 20'hFFFFF, 16'hFFFF, 1'b1, krt_pkg::ST_DONE, 1, 0, 2);
		add_row(krt_pkg::OP_INSERT, 20'h12345, 16'hA5A5, 1'b1, krt_pkg::ST_DONE, 2, 0, 3);
		add_row(krt_pkg::OP_INSERT, 20'h00000, 16'h5A5A, 1'b1, krt_pkg::ST_DONE, 3, 0, 4);
		add_row(krt_pkg::OP_LOOKUP, 20'hFFFFF, 16'h0000, 1'b1, krt_pkg::ST_DONE, 1, 'hFFFF, 4);
		add_row(krt_pkg::OP_LOOKUP, 20'h00000, 16'hFFFF, 1'b1, krt_pkg::ST_DONE, 0, 0, 4);
		add_row(krt_pkg::OP_LOOKUP, 20'h54321, 16'h0000, 1'b1, krt_pkg::ST_NOTFOUND, 0, 0, 4);
		add_row(krt_pkg::OP_SORT,   20'hFFFFF, 16'hFFFF, 1'b1, krt_pkg::ST_DONE, 0, 0, 4);
		add_row(krt_pkg::OP_LOOKUP, 20'h00000, 16'h0000, 1'b0, krt_pkg::ST_DONE, 0, 0, 0);
		add_row(krt_pkg::OP_LOOKUP, 20'hFFFFF, 16'h0000, 1'b0, krt_pkg::ST_DONE, 0, 0, 0);
		add_row(krt_pkg::OP_DELETE, 20'h00000, 16'h0000, 1'b1, krt_pkg::ST_DONE, 0, 0, 2);
		add_row(krt_pkg::OP_DELETE, 20'h00000, 16'h0000, 1'b1, krt_pkg::ST_NOTFOUND, 0, 0, 2);
		add_row(krt_pkg::OP_LOOKUP, 20'h12345, 16'h0000, 1'b0, krt_pkg::ST_DONE, 0, 0, 0);
		add_row(krt_pkg::OP_INSERT, 20'h00007, 16'h0001, 1'b0, krt_pkg::ST_DONE, 0, 0, 0);
		add_row(krt_pkg::OP_INSERT, 20'h00003, 16'h0002, 1'b0, krt_pkg::ST_DONE, 0, 0, 0);
		add_row(krt_pkg::OP_SORT,   20'h00000, 16'h0000, 1'b0, krt_pkg::ST_DONE, 0, 0, 0);
		add_row(krt_pkg::OP_LOOKUP, 20'h00003, 16'h0000, 1'b0, krt_pkg::ST_DONE, 0, 0, 0);
		add_row(krt_pkg::OP_DELETE, 20'hFFFFF, 16'h0000, 1'b0, krt_pkg::ST_DONE, 0, 0, 0);
		add_row(krt_pkg::OP_DELETE, 20'h00003, 16'h0000, 1'b0, krt_pkg::ST_DONE, 0, 0, 0);
		add_row(krt_pkg::OP_DELETE, 20'h00007, 16'h0000, 1'b0, krt_pkg::ST_DONE, 0, 0, 0);
		add_row(krt_pkg::OP_DELETE, 20'h12345, 16'h0000, 1'b0, krt_pkg::ST_DONE, 0, 0, 0);
		foreach (directed[k])
			issue_op(directed[k].op, directed[k].key, directed[k].pay,
				directed[k].chk, directed[k].resp);

		refresh_pool();
		run_small(290);

		// fill to the brim from pool keys, probe, sort once at full size, then empty
		refresh_pool();
		while (tbl_count < TBL_DEPTH)
			issue_op(krt_pkg::OP_INSERT, key_pool[$urandom_range(0, POOL_N - 1)],
				krt_pkg::PAY_W'($urandom), 1'b0, '0);
		repeat (3)
			issue_op(krt_pkg::OP_INSERT, pick_key(), krt_pkg::PAY_W'($urandom), 1'b0, '0);
		issue_op(krt_pkg::OP_LOOKUP, key_pool[1], '0, 1'b0, '0);
		issue_op(krt_pkg::OP_LOOKUP, key_pool[0], '0, 1'b0, '0);
		issue_op(krt_pkg::OP_LOOKUP, krt_pkg::KEY_W'($urandom), '0, 1'b0, '0);
		issue_op(krt_pkg::OP_SORT, '0, '0, 1'b0, '0);
		for (i = 0; i < 4; i++)
			issue_op(krt_pkg::OP_LOOKUP, key_pool[$urandom_range(0, POOL_N - 1)], '0,
				1'b0, '0);
		for (i = 0; i < POOL_N; i++)
			issue_op(krt_pkg::OP_DELETE, key_pool[i], krt_pkg::PAY_W'($urandom), 1'b0, '0);

		refresh_pool();
		run_small(290);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_resp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
